/* src/csem_pkg.sv */
package csem_pkg;

  // Table geometry and register reset values
  localparam int          ENTRIES_DEF = 16;
  localparam logic [31:0] KBASE_RST   = 32'h0080_0000;

  // Configuration register byte addresses
  localparam logic [1:0]  REG_KBASE   = 2'd0;

  // Operation codes carried on in_func
  typedef enum logic [1:0] {
    FN_CREATE  = 2'd0,
    FN_ACQUIRE = 2'd1,
    FN_RELEASE = 2'd2
  } func_t;

  // One semaphore entry as stored in the table memory
  typedef struct packed {
    logic [31:0] owner;
    logic [31:0] addr;
    logic [15:0] count;
    logic [15:0] limit;
  } entry_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_t;

endpackage

/* src/counting_semaphore_table_core.sv */
// Counting semaphore table. Each transfer on the in_ channel carries one
// operation (create, acquire or release) and yields exactly one transfer on
// the out_ channel with out_granted set on success. The entries live in a
// single-port synchronous memory that a sequencer scans from entry 0 upward,
// one entry per cycle with the next read overlapped on the current compare,
// and the first hit, when the operation succeeds, is modified and written
// back in the same cycle. An item goes from ST_IDLE through ST_SCAN, which
// ends at the first hit or the last entry, and ST_RESP into the output
// register; an unused code skips ST_SCAN. One item is in work at a time; a
// finished result waits in the output register while the next item is taken.
// Per-entry valid flops make the table read as all zero right after reset,
// so no clearing pass is needed. kernel_space_base sits at byte address 0 of
// the APB port and should only be written while no operation is in flight.
module counting_semaphore_table_core
  import csem_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // operation channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_owner_id,
  input  logic [31:0] in_lock_address,
  input  logic [15:0] in_initial_count,
  input  logic [15:0] in_count_limit,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_granted,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] RD_END   = CW'(ENTRIES);
  localparam logic [IW-1:0] IDX_LAST = IW'(ENTRIES - 1);

  state_t state_r, state_nxt;

  logic [1:0]    func_r;
  logic [31:0]   owner_r;
  logic [31:0]   addr_r;
  logic [15:0]   cnt_r;
  logic [15:0]   lim_r;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          chk_vld_r;
  logic [IW-1:0] chk_idx_r;
  entry_t        mem_q_r;
  logic          vld_q_r;
  logic [ENTRIES-1:0] vld_r;
  logic          grant_r, grant_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_granted_r;
  logic [31:0]   kbase_r;

  entry_t        mem [ENTRIES];

  logic   in_acc;
  logic   out_acc;
  logic   cfg_wr;
  entry_t ent;
  entry_t wr_ent;
  logic   high;
  logic   hit;
  logic   ok;
  logic   fin;
  logic   found;
  logic   wr_en;
  logic   rd_en;
  logic   resp_go;

  // Handshakes
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_granted = out_granted_r;

  // Configuration register
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_KBASE) ? kbase_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbase_r <= KBASE_RST;
    end else if (cfg_wr && (paddr == REG_KBASE)) begin
      kbase_r <= pwdata;
    end
  end

  // Entry under compare; a never-written entry reads as zero
  assign ent  = vld_q_r ? mem_q_r : '0;
  assign high = (addr_r >= kbase_r);

  // Match and modify the entry under compare
  always_comb begin
    hit    = 1'b0;
    ok     = 1'b0;
    wr_ent = ent;
    unique case (func_r)
      FN_CREATE: begin
        hit    = (ent.owner == '0);
        ok     = 1'b1;
        wr_ent = '{owner: owner_r, addr: addr_r, count: cnt_r, limit: lim_r};
      end
      FN_ACQUIRE: begin
        hit          = (ent.addr == addr_r) && (high || (ent.owner == owner_r));
        ok           = (ent.count != '0);
        wr_ent.count = ent.count - 16'd1;
      end
      FN_RELEASE: begin
        hit          = (ent.owner == owner_r) && (ent.addr == addr_r);
        ok           = !((ent.count == ent.limit) || (ent.count == '1));
        wr_ent.count = ent.count + 16'd1;
      end
      default: begin
        hit = 1'b0;
        ok  = 1'b0;
      end
    endcase
  end

  assign found = (state_r == ST_SCAN) && chk_vld_r && hit;
  assign fin   = (state_r == ST_SCAN) && chk_vld_r && (hit || (chk_idx_r == IDX_LAST));
  assign wr_en = found && ok;
  assign rd_en = (state_r == ST_SCAN) && !fin && (rd_idx_r < RD_END);

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[chk_idx_r] <= wr_ent;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_idx_r[IW-1:0]];
      vld_q_r <= vld_r[rd_idx_r[IW-1:0]];
    end
  end

  // Mark entries once written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[chk_idx_r] <= 1'b1;
    end
  end

  // Latch the operation on transfer in
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= in_func;
      owner_r <= in_owner_id;
      addr_r  <= in_lock_address;
      cnt_r   <= in_initial_count;
      lim_r   <= in_count_limit;
    end
  end

  // Sequencer
  assign resp_go = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    grant_nxt     = grant_r;
    out_valid_nxt = out_valid_r && !out_acc;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rd_idx_nxt = '0;
          grant_nxt  = 1'b0;
          if ((in_func == FN_CREATE) || (in_func == FN_ACQUIRE) ||
              (in_func == FN_RELEASE)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (fin) begin
          grant_nxt = found && ok;
          state_nxt = ST_RESP;
        end else if (rd_en) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
      end
      ST_RESP: begin
        if (resp_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      chk_vld_r   <= 1'b0;
      grant_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_vld_r   <= rd_en;
      grant_r     <= grant_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Track which entry the registered read data belongs to
  always_ff @(posedge clk) begin
    if (rd_en) begin
      chk_idx_r <= rd_idx_r[IW-1:0];
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if ((state_r == ST_RESP) && resp_go) begin
      out_granted_r <= grant_r;
    end
  end

endmodule

/* src/csem_checker.sv */
module csem_checker
  import csem_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_granted,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [1:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_granted))
    else $error("stalled result changed");

  // Block further operations while one is in work
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("operation accepted while another is in work");

  // Read back a register write
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr == REG_KBASE) |=>
      (prdata == $past(pwdata)))
    else $error("register write not visible on read");

  // Come out of reset idle with no result pending
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or busy state survived reset");

endmodule

bind counting_semaphore_table_core csem_checker u_csem_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import csem_pkg::*;

  // Opcode the block leaves unused; it must always be denied
  localparam logic [1:0]  FN_UNUSED   = 2'd3;
  localparam logic [15:0] COUNT_SAT   = 16'hFFFF;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          BUSY_CAP    = 12;

  localparam logic [31:0] OWNER_POOL [6] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                                             32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFF};
  localparam logic [31:0] ADDR_POOL [8] = '{32'h0000_0000, 32'h0000_1000, 32'h007F_FFFC,
                                            32'h0080_0000, 32'h0080_0040, 32'h7FFF_FFF0,
                                            32'h8000_0000, 32'hFFFF_FFFF};

  // Shadow of the semaphore table plus the queue of outstanding grant decisions
  class grant_tracker;
    logic [31:0] kbase;
    logic [31:0] owner_tab [ENTRIES_DEF];
    logic [31:0] addr_tab  [ENTRIES_DEF];
    logic [15:0] count_tab [ENTRIES_DEF];
    logic [15:0] limit_tab [ENTRIES_DEF];
    logic        pending_grants [$];
    int          mismatches;
    int          grants;
    int          denials;

    function new();
      kbase = KBASE_RST;
      foreach (owner_tab[i]) begin
        owner_tab[i] = '0;
        addr_tab[i]  = '0;
        count_tab[i] = '0;
        limit_tab[i] = '0;
      end
      mismatches = 0;
      grants     = 0;
      denials    = 0;
    endfunction

    // Number of entries held by a nonzero owner (never reusable)
    function int busy_entries();
      int n;
      n = 0;
      foreach (owner_tab[i]) if (owner_tab[i] != '0) n++;
      return n;
    endfunction

    // Apply one operation to the shadow table and return the grant bit
    function logic predict_grant(logic [1:0] fn, logic [31:0] owner, logic [31:0] addr,
                                 logic [15:0] cnt, logic [15:0] lim);
      bit high;
      high = (addr >= kbase);
      case (fn)
        FN_CREATE: begin
          for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (owner_tab[i] == '0) begin
              owner_tab[i] = owner;
              addr_tab[i]  = addr;
              count_tab[i] = cnt;
              limit_tab[i] = lim;
              return 1'b1;
            end
          end
          return 1'b0;
        end
        FN_ACQUIRE: begin
          for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (addr_tab[i] == addr && (high || owner_tab[i] == owner)) begin
              if (count_tab[i] == '0) return 1'b0;
              count_tab[i] = count_tab[i] - 16'd1;
              return 1'b1;
            end
          end
          return 1'b0;
        end
        FN_RELEASE: begin
          for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (owner_tab[i] == owner && addr_tab[i] == addr) begin
              if (count_tab[i] == limit_tab[i] || count_tab[i] == COUNT_SAT) return 1'b0;
              count_tab[i] = count_tab[i] + 16'd1;
              return 1'b1;
            end
          end
          return 1'b0;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_op(logic [1:0] fn, logic [31:0] owner, logic [31:0] addr,
                          logic [15:0] cnt, logic [15:0] lim);
      pending_grants.push_back(predict_grant(fn, owner, addr, cnt, lim));
    endfunction

    function void check_grant(logic actual);
      logic want;
      if (pending_grants.size() == 0) begin
        $error("granted: no result expected, actual %0b", actual);
        mismatches++;
        return;
      end
      want = pending_grants.pop_front();
      if (actual !== want) begin
        $error("granted: expected %0b, actual %0b", want, actual);
        mismatches++;
      end else if (want) begin
        grants++;
      end else begin
        denials++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = FN_CREATE;
  logic [31:0] in_owner_id = '0;
  logic [31:0] in_lock_address = '0;
  logic [15:0] in_initial_count = '0;
  logic [15:0] in_count_limit = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_granted;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = REG_KBASE;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grant_tracker sb = new();
  int tx_idle_pct  = 29;
  int rx_stall_pct = 88;
  int cycle_count  = 0;
  int ops_sent     = 0;
  int kbase_writes = 0;

  counting_semaphore_table_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_owner_id      (in_owner_id),
    .in_lock_address  (in_lock_address),
    .in_initial_count (in_initial_count),
    .in_count_limit   (in_count_limit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted      (out_granted),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Check each result transfer, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_grant(out_granted);
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Present one operation, hold it until the transfer, then record it
  task automatic send_op(logic [1:0] fn, logic [31:0] owner, logic [31:0] addr,
                         logic [15:0] cnt, logic [15:0] lim);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_func          <= fn;
    in_owner_id      <= owner;
    in_lock_address  <= addr;
    in_initial_count <= cnt;
    in_count_limit   <= lim;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_op(fn, owner, addr, cnt, lim);
    ops_sent++;
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_grants.size() != 0) @(posedge clk);
  endtask

  // Write kernel_space_base over APB and read it back
  task automatic set_kbase(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_KBASE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $error("kernel_space_base: expected %h, actual %h", value, prdata);
      sb.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.kbase = value;
    kbase_writes++;
  endtask

  // One random operation, mostly aimed at live entries
  task automatic random_op();
    int          r;
    int          pick;
    logic [1:0]  fn;
    logic [31:0] owner;
    logic [31:0] addr;
    logic [15:0] cnt;
    logic [15:0] lim;
    r     = $urandom_range(99);
    pick  = $urandom_range(ENTRIES_DEF - 1);
    cnt   = 16'($urandom_range(4));
    lim   = 16'($urandom_range(4));
    owner = OWNER_POOL[$urandom_range(5)];
    addr  = ADDR_POOL[$urandom_range(7)];
    if (r < 10) begin
      // noise: every field fully random, unused opcode included
      fn    = 2'($urandom_range(3));
      owner = $urandom;
      addr  = $urandom;
      cnt   = 16'($urandom);
      lim   = 16'($urandom);
    end else if (r < 25) begin
      fn = FN_CREATE;
      if ($urandom_range(3) == 0) begin
        cnt = 16'($urandom);
        lim = 16'($urandom);
      end
      // keep a few entries reusable so creates keep landing
      if (sb.busy_entries() >= BUSY_CAP) owner = '0;
    end else begin
      fn = ($urandom_range(1) == 0) ? FN_ACQUIRE : FN_RELEASE;
      if ($urandom_range(4) != 0) begin
        owner = sb.owner_tab[pick];
        addr  = sb.addr_tab[pick];
        if (fn == FN_ACQUIRE && $urandom_range(3) == 0) owner = OWNER_POOL[$urandom_range(5)];
      end
    end
    send_op(fn, owner, addr, cnt, lim);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, unused opcode, count bounds, owner-0 entries, saturation
    send_op(FN_ACQUIRE, 32'h0, 32'h0, 16'h0, 16'h0);
    send_op(FN_RELEASE, 32'h0, 32'h0, 16'h0, 16'h0);
    send_op(FN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_op(FN_CREATE, 32'hFFFF_FFFF, 32'h0000_1000, 16'h1, 16'h2);
    send_op(FN_ACQUIRE, 32'hFFFF_FFFF, 32'h0000_1000, 16'h0, 16'h0);
    send_op(FN_ACQUIRE, 32'hFFFF_FFFF, 32'h0000_1000, 16'h0, 16'h0);
    send_op(FN_ACQUIRE, 32'h0000_0005, 32'h0000_1000, 16'h0, 16'h0);
    send_op(FN_RELEASE, 32'hFFFF_FFFF, 32'h0000_1000, 16'h0, 16'h0);
    send_op(FN_RELEASE, 32'hFFFF_FFFF, 32'h0000_1000, 16'h0, 16'h0);
    send_op(FN_RELEASE, 32'hFFFF_FFFF, 32'h0000_1000, 16'h0, 16'h0);
    send_op(FN_CREATE, 32'h0000_0007, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_op(FN_ACQUIRE, 32'h0000_0009, 32'hFFFF_FFFF, 16'h0, 16'h0);
    send_op(FN_RELEASE, 32'h0000_0009, 32'hFFFF_FFFF, 16'h0, 16'h0);
    send_op(FN_CREATE, 32'h0, 32'h0000_2000, 16'h3, 16'h3);
    send_op(FN_ACQUIRE, 32'h0, 32'h0000_2000, 16'h0, 16'h0);
    send_op(FN_RELEASE, 32'h0, 32'h0000_2000, 16'h0, 16'h0);
    send_op(FN_CREATE, 32'h0000_0003, 32'h0000_3000, 16'hFFFE, 16'h0);
    send_op(FN_RELEASE, 32'h0000_0003, 32'h0000_3000, 16'h0, 16'h0);
    send_op(FN_RELEASE, 32'h0000_0003, 32'h0000_3000, 16'h0, 16'h0);
    send_op(FN_RELEASE, 32'h0, 32'h0000_2000, 16'h0, 16'h0);
    send_op(FN_ACQUIRE, 32'h0000_0003, 32'h0000_3000, 16'h0, 16'h0);
    drain_results();

    // Slow receiver, every address high
    set_kbase(32'h0000_0000);
    for (int i = 0; i < 340; i++) begin
      random_op();
      if (i == 170) drain_results();
    end
    drain_results();

    // Slow sender, only the top address high
    tx_idle_pct  = 88;
    rx_stall_pct = 29;
    set_kbase(32'hFFFF_FFFF);
    repeat (340) random_op();
    drain_results();

    // Back-to-back at the default boundary, then fill the table to the brim
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_kbase(KBASE_RST);
    repeat (300) random_op();
    for (int k = 0; k < 20; k++)
      send_op(FN_CREATE, 32'h0000_0100 + k, ADDR_POOL[k % 8], 16'h1, 16'h1);
    repeat (20) random_op();
    drain_results();
    repeat (30) @(posedge clk);

    $display("Sent %0d operations across %0d boundary settings; %0d granted, %0d denied.",
             ops_sent, kbase_writes + 1, sb.grants, sb.denials);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* counting_semaphore_table_core.f */
src/csem_pkg.sv
src/counting_semaphore_table_core.sv
src/csem_checker.sv
sim/testbench.sv
